### rtl/rrqs_pkg.sv
// ----------------------------------------------------------------------------
// rrqs_pkg: shared types and constants of the round-robin quantum scheduler
// Transaction payloads, command and status codes, slot state codes, widths.
// ----------------------------------------------------------------------------
package rrqs_pkg;

  localparam int MAX_THREADS   = 16;
  localparam int MAX_PROCESSES = 16;
  localparam int TH_W          = 4;   // slot index width
  localparam int PR_W          = 4;   // process index width
  localparam int CNT_W         = 5;   // slot count, holds MAX_THREADS
  localparam int TICK_W        = 8;   // quantum / tick counter width
  localparam int APB_AW        = 2;
  localparam int APB_DW        = 32;

  localparam logic [TICK_W-1:0] QUANTUM_RESET = TICK_W'(10);

  // register map
  localparam logic [APB_AW-1:0] ADDR_QUANTUM = '0;

  // commands
  localparam logic [2:0] CMD_TICK        = 3'd0;
  localparam logic [2:0] CMD_CREATE      = 3'd1;
  localparam logic [2:0] CMD_TERM_THREAD = 3'd2;
  localparam logic [2:0] CMD_TERM_PROC   = 3'd3;
  localparam logic [2:0] CMD_SET_CUR     = 3'd4;

  // status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_INVALID = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;

  // slot states
  localparam logic [1:0] SS_READY   = 2'd1;
  localparam logic [1:0] SS_RUNNING = 2'd2;
  localparam logic [1:0] SS_DEAD    = 2'd3;

  typedef struct packed {
    logic [2:0]      cmd;
    logic [TH_W-1:0] thread_index;
    logic [PR_W-1:0] process_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [TH_W-1:0] new_thread;
    logic [TH_W-1:0] current_thread;
    logic            switched;
  } out_item_t;

  typedef struct packed {
    logic [1:0]      state;
    logic [PR_W-1:0] owner;
  } slot_word_t;

endpackage

### rtl/rrqs_core.sv
// ----------------------------------------------------------------------------
// rrqs_core: scheduler sequencer around the slot memories
// Slot state/owner and saved tick memories, read-modify-write sequencer.
// ----------------------------------------------------------------------------
module rrqs_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [rrqs_pkg::TICK_W-1:0] quantum,
  input  logic                      start,
  input  rrqs_pkg::in_item_t        item,
  output logic                      idle,
  output logic                      fin,
  output rrqs_pkg::out_item_t       res,
  input  logic                      res_ready
);
  import rrqs_pkg::*;

  typedef enum logic [9:0] {
    ST_INIT = 10'b0000000001,
    ST_IDLE = 10'b0000000010,
    ST_TCUR = 10'b0000000100,
    ST_SCAN = 10'b0000001000,
    ST_SW1  = 10'b0000010000,
    ST_SW2  = 10'b0000100000,
    ST_TT   = 10'b0001000000,
    ST_TP   = 10'b0010000000,
    ST_SC   = 10'b0100000000,
    ST_FIN  = 10'b1000000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [TH_W-1:0]   cur_r, cur_nxt;
  logic [CNT_W-1:0]  used_r, used_nxt;
  logic [TICK_W-1:0] ticks_r, ticks_nxt;
  logic [TH_W-1:0]   th_r, th_nxt;
  logic [PR_W-1:0]   pr_r, pr_nxt;
  logic [TH_W-1:0]   chk_r, chk_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [TH_W-1:0]   pick_r, pick_nxt;
  logic [PR_W-1:0]   pick_own_r, pick_own_nxt;
  slot_word_t        cur_word_r, cur_word_nxt;
  logic [1:0]        stat_r, stat_nxt;
  logic [TH_W-1:0]   newt_r, newt_nxt;
  logic              sw_r, sw_nxt;

  // slot memory {state, owner} and saved-ticks memory
  slot_word_t        smem [MAX_THREADS];
  logic [TICK_W-1:0] tmem [MAX_THREADS];
  slot_word_t        sm_rdata_r;
  logic [TICK_W-1:0] tm_rdata_r;
  logic              sm_we, tm_we;
  logic [TH_W-1:0]   sm_wa, sm_ra, tm_wa, tm_ra;
  slot_word_t        sm_wd;
  logic [TICK_W-1:0] tm_wd;

  logic th_ok, pr_ok, tbl_full, runnable;

  function automatic logic [TH_W-1:0] wrap_inc(input logic [TH_W-1:0] x,
                                               input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] s;
    s = CNT_W'(x) + CNT_W'(1);
    return (s == n) ? '0 : s[TH_W-1:0];
  endfunction

  assign th_ok    = CNT_W'(item.thread_index) < used_r;
  assign pr_ok    = {1'b0, item.process_index} < (PR_W+1)'(MAX_PROCESSES);
  assign tbl_full = used_r == CNT_W'(MAX_THREADS);
  assign runnable = (sm_rdata_r.state == SS_READY) || (sm_rdata_r.state == SS_RUNNING);

  assign idle = state_r == ST_IDLE;
  assign fin  = state_r == ST_FIN;
  assign res  = '{status: stat_r, new_thread: newt_r, current_thread: cur_r,
                  switched: sw_r};

  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    used_nxt     = used_r;
    ticks_nxt    = ticks_r;
    th_nxt       = th_r;
    pr_nxt       = pr_r;
    chk_nxt      = chk_r;
    rem_nxt      = rem_r;
    pick_nxt     = pick_r;
    pick_own_nxt = pick_own_r;
    cur_word_nxt = cur_word_r;
    stat_nxt     = stat_r;
    newt_nxt     = newt_r;
    sw_nxt       = sw_r;
    sm_we        = 1'b0;
    sm_wa        = chk_r;
    sm_wd        = cur_word_r;
    sm_ra        = chk_r;
    tm_we        = 1'b0;
    tm_wa        = cur_r;
    tm_wd        = ticks_r;
    tm_ra        = th_r;

    unique case (state_r)
      ST_INIT: begin
        // slot 0 is the idle thread of process 0
        sm_we     = 1'b1;
        sm_wa     = '0;
        sm_wd     = '{state: SS_READY, owner: '0};
        tm_we     = 1'b1;
        tm_wa     = '0;
        tm_wd     = QUANTUM_RESET;
        state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          th_nxt    = item.thread_index;
          pr_nxt    = item.process_index;
          stat_nxt  = STAT_OK;
          newt_nxt  = '0;
          sw_nxt    = 1'b0;
          state_nxt = ST_FIN;
          case (item.cmd)
            CMD_TICK: begin
              ticks_nxt = (ticks_r != '0) ? ticks_r - TICK_W'(1) : ticks_r;
              sm_ra     = cur_r;
              state_nxt = ST_TCUR;
            end
            CMD_CREATE: begin
              if (!pr_ok) begin
                stat_nxt = STAT_INVALID;
              end else if (tbl_full) begin
                stat_nxt = STAT_FULL;
              end else begin
                sm_we    = 1'b1;
                sm_wa    = used_r[TH_W-1:0];
                sm_wd    = '{state: SS_READY, owner: item.process_index};
                tm_we    = 1'b1;
                tm_wa    = used_r[TH_W-1:0];
                tm_wd    = quantum;
                newt_nxt = used_r[TH_W-1:0];
                used_nxt = used_r + CNT_W'(1);
              end
            end
            CMD_TERM_THREAD: begin
              if (!th_ok) begin
                stat_nxt = STAT_INVALID;
              end else begin
                sm_ra     = item.thread_index;
                state_nxt = ST_TT;
              end
            end
            CMD_TERM_PROC: begin
              if (!pr_ok) begin
                stat_nxt = STAT_INVALID;
              end else begin
                sm_ra     = '0;
                chk_nxt   = '0;
                rem_nxt   = used_r;
                state_nxt = ST_TP;
              end
            end
            CMD_SET_CUR: begin
              if (!th_ok) begin
                stat_nxt = STAT_INVALID;
              end else if (item.thread_index != cur_r) begin
                tm_ra     = item.thread_index;
                state_nxt = ST_SC;
              end
            end
            default: stat_nxt = STAT_INVALID;
          endcase
        end
      end
      ST_TCUR: begin
        cur_word_nxt = sm_rdata_r;
        if ((ticks_r != '0 && sm_rdata_r.state == SS_RUNNING) ||
            used_r == CNT_W'(1)) begin
          state_nxt = ST_FIN;
        end else begin
          chk_nxt   = wrap_inc(cur_r, used_r);
          sm_ra     = wrap_inc(cur_r, used_r);
          rem_nxt   = used_r - CNT_W'(1);
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // one candidate per cycle; next read is issued speculatively
        sm_ra = wrap_inc(chk_r, used_r);
        if (runnable) begin
          pick_nxt     = chk_r;
          pick_own_nxt = sm_rdata_r.owner;
          state_nxt    = ST_SW1;
        end else if (rem_r == CNT_W'(1)) begin
          state_nxt = ST_FIN;
        end else begin
          chk_nxt = wrap_inc(chk_r, used_r);
          rem_nxt = rem_r - CNT_W'(1);
        end
      end
      ST_SW1: begin
        sm_we     = 1'b1;
        sm_wa     = pick_r;
        sm_wd     = '{state: SS_RUNNING, owner: pick_own_r};
        tm_we     = 1'b1;
        tm_wa     = cur_r;
        tm_wd     = ticks_r;
        ticks_nxt = quantum;
        state_nxt = ST_SW2;
      end
      ST_SW2: begin
        sm_we     = 1'b1;
        sm_wa     = cur_r;
        sm_wd     = '{state: (cur_word_r.state == SS_DEAD) ? SS_DEAD : SS_READY,
                      owner: cur_word_r.owner};
        cur_nxt   = pick_r;
        sw_nxt    = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_TT: begin
        sm_we     = 1'b1;
        sm_wa     = th_r;
        sm_wd     = '{state: SS_DEAD, owner: sm_rdata_r.owner};
        state_nxt = ST_FIN;
      end
      ST_TP: begin
        if (sm_rdata_r.owner == pr_r) begin
          sm_we = 1'b1;
          sm_wa = chk_r;
          sm_wd = '{state: SS_DEAD, owner: sm_rdata_r.owner};
        end
        sm_ra = chk_r + TH_W'(1);
        if (rem_r == CNT_W'(1)) begin
          state_nxt = ST_FIN;
        end else begin
          chk_nxt = chk_r + TH_W'(1);
          rem_nxt = rem_r - CNT_W'(1);
        end
      end
      ST_SC: begin
        tm_we     = 1'b1;
        tm_wa     = cur_r;
        tm_wd     = ticks_r;
        ticks_nxt = tm_rdata_r;
        cur_nxt   = th_r;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (sm_we) begin
      smem[sm_wa] <= sm_wd;
    end
    sm_rdata_r <= smem[sm_ra];
    if (tm_we) begin
      tmem[tm_wa] <= tm_wd;
    end
    tm_rdata_r <= tmem[tm_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      cur_r   <= '0;
      used_r  <= CNT_W'(1);
      ticks_r <= QUANTUM_RESET;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      used_r  <= used_nxt;
      ticks_r <= ticks_nxt;
    end
  end

  always_ff @(posedge clk) begin
    th_r       <= th_nxt;
    pr_r       <= pr_nxt;
    chk_r      <= chk_nxt;
    rem_r      <= rem_nxt;
    pick_r     <= pick_nxt;
    pick_own_r <= pick_own_nxt;
    cur_word_r <= cur_word_nxt;
    stat_r     <= stat_nxt;
    newt_r     <= newt_nxt;
    sw_r       <= sw_nxt;
  end

endmodule

### rtl/round_robin_quantum_scheduler_unit.sv
// ----------------------------------------------------------------------------
// round_robin_quantum_scheduler_unit: round-robin time-slice thread scheduler
// Top level: APB quantum register, command channel, registered result channel.
// ----------------------------------------------------------------------------
// The scheduler keeps a 16-slot thread table in two small synchronous memories
// (slot state and owner, saved quantum) and handles one command transaction
// at a time; a new command is taken while the previous result still waits in
// the output register. A tick may run a rotating search over at most
// slots_used - 1 slots and then switch the current thread; terminate process
// sweeps all slots_used slots. The search and the sweep visit one slot per
// cycle, as the slot memory has a single read port. After reset the block
// writes the idle thread into slot 0 in its init state and takes no command
// during it; the quantum register can be written at any time and is read back
// at address 0.
module round_robin_quantum_scheduler_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  // command channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  rrqs_pkg::in_item_t          in_data,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output rrqs_pkg::out_item_t         out_data,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rrqs_pkg::APB_AW-1:0] paddr,
  input  logic [rrqs_pkg::APB_DW-1:0] pwdata,
  output logic [rrqs_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import rrqs_pkg::*;

  logic [TICK_W-1:0] quantum_r, quantum_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic      core_idle;
  logic      core_fin;
  out_item_t core_res;
  logic      out_free;
  logic      cfg_wr;

  // --- configuration: quantum register ------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_QUANTUM);
  assign prdata = (paddr == ADDR_QUANTUM) ? APB_DW'(quantum_r) : '0;

  always_comb begin
    quantum_nxt = quantum_r;
    if (cfg_wr) begin
      quantum_nxt = pwdata[TICK_W-1:0];
    end
  end

  // --- command handshake --------------------------------------------------
  // stall whenever the sequencer is not idle: init, busy, or holding its result
  assign in_stall = !core_idle;

  rrqs_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .quantum   (quantum_r),
    .start     (in_valid),
    .item      (in_data),
    .idle      (core_idle),
    .fin       (core_fin),
    .res       (core_res),
    .res_ready (out_free)
  );

  // --- result register ----------------------------------------------------
  // free when empty or being taken at this edge
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (core_fin && out_free) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = core_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r   <= QUANTUM_RESET;
      out_valid_r <= 1'b0;
    end else begin
      quantum_r   <= quantum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule
